>>> hw/rtl/pabp_pkg.sv
package pabp_pkg;

  // Fixed widths of the request and result fields
  localparam int CMD_W       = 3;
  localparam int THREAD_W    = 2;
  localparam int ADDR_W      = 10;
  localparam int SNAP_HIST_W = 8;
  localparam int SNAP_IDX_W  = 10;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP     = 3'd0,
    CMD_UPDATE     = 3'd1,
    CMD_SQUASH     = 3'd2,
    CMD_BTB_UPDATE = 3'd3,
    CMD_UNCOND     = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HIST,
    ST_CTR
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]       cmd;
    logic [THREAD_W-1:0]    thread;
    logic [ADDR_W-1:0]      branch_address;
    logic                   outcome_taken;
    logic                   was_squashed;
    logic [SNAP_HIST_W-1:0] snapshot_history;
    logic [SNAP_IDX_W-1:0]  snapshot_index;
  } req_t;

  typedef struct packed {
    logic hist_we;
    logic ctr_we;
    logic use_snap_index;
  } exec_ctrl_t;

endpackage

>>> hw/rtl/per_address_two_level_branch_predictor_unit.sv
// Per-address two-level branch predictor.
// Input channel (in_valid / in_stall) carries one request: a command (lookup,
// update, squash, BTB update, unconditional branch), the thread, the branch
// address and the resolved outcome / snapshot fields. Output channel
// (out_valid / out_stall) returns exactly one result per request: the
// prediction and the history snapshot for a lookup, all zero otherwise.
// For each request, the local history memory is read at the accepting edge,
// then the counter memory at the row that history selects, and last both are
// written back and the result is loaded.
// A new request is accepted only after the previous one is written back; the
// next history read waits until that write-back is done, and a stalled output
// holds it back further.
// After reset the block sweeps every entry of both memories to zero, one entry
// a cycle; in_stall stays high during the sweep.
// The result sits in an output register: while out_stall is high it holds,
// the next request may already be accepted, and it waits in the write-back
// step until the output register frees up.
module per_address_two_level_branch_predictor_unit #(
  parameter int THREADS         = 4,
  parameter int HIST_INDEX_BITS = 10,
  parameter int ROW_BITS        = 8,
  parameter int COL_BITS        = 4,
  parameter int HIST_BITS       = 8,
  parameter int CTR_BITS        = 2
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [pabp_pkg::CMD_W-1:0]        cmd,
  input  logic [pabp_pkg::THREAD_W-1:0]     thread,
  input  logic [pabp_pkg::ADDR_W-1:0]       branch_address,
  input  logic                              outcome_taken,
  input  logic                              was_squashed,
  input  logic [pabp_pkg::SNAP_HIST_W-1:0]  snapshot_history,
  input  logic [pabp_pkg::SNAP_IDX_W-1:0]   snapshot_index,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              predict_taken,
  output logic [pabp_pkg::SNAP_HIST_W-1:0]  saved_history,
  output logic [pabp_pkg::SNAP_IDX_W-1:0]   saved_index
);
  import pabp_pkg::*;

  localparam int TIDX_W     = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int HIST_AW    = TIDX_W + HIST_INDEX_BITS;
  localparam int CTR_AW     = ROW_BITS + COL_BITS;
  localparam int CLR_W      = (HIST_AW > CTR_AW) ? HIST_AW : CTR_AW;
  localparam int HIST_DEPTH = 1 << HIST_AW;
  localparam int CTR_DEPTH  = 1 << CTR_AW;
  localparam int TID_X_W    = TIDX_W + THREAD_W;
  localparam int IDX_X_W    = HIST_INDEX_BITS + ADDR_W;
  localparam int SIDX_X_W   = HIST_INDEX_BITS + SNAP_IDX_W;
  localparam logic [31:0] ROW_MASK = 32'((64'd1 << ROW_BITS) - 64'd1);
  localparam logic [31:0] COL_MASK = 32'((64'd1 << COL_BITS) - 64'd1);

  // Storage: local histories per thread, shared pattern counters
  logic [HIST_BITS-1:0] hist_mem [HIST_DEPTH];
  logic [CTR_BITS-1:0]  ctr_mem  [CTR_DEPTH];
  logic [HIST_BITS-1:0] hist_rdata;
  logic [CTR_BITS-1:0]  ctr_rdata;

  state_t               state;
  state_t               state_next;
  logic [CLR_W-1:0]     clr;
  req_t                 req;
  req_t                 req_in;

  logic                 accept;
  logic                 out_free;
  logic                 clearing;
  logic                 ctr_rd;
  logic                 commit;

  logic [TID_X_W-1:0]   tid_in_x;
  logic [TID_X_W-1:0]   tid_q_x;
  logic [IDX_X_W-1:0]   idx_in_x;
  logic [IDX_X_W-1:0]   idx_q_x;
  logic [SIDX_X_W-1:0]  sidx_q_x;
  logic [HIST_AW-1:0]   hist_raddr;
  logic [HIST_INDEX_BITS-1:0] idx_q;
  logic [HIST_INDEX_BITS-1:0] sidx_q;
  logic [HIST_AW-1:0]   commit_haddr;
  logic                 thread_ok;

  logic [31:0]          row_w;
  logic [31:0]          ctr_addr_w;
  logic [CTR_AW-1:0]    ctr_addr_q;

  exec_ctrl_t           ctrl;
  logic [HIST_BITS-1:0] exec_hist;
  logic [CTR_BITS-1:0]  exec_ctr;
  logic                 exec_predict;
  logic [SNAP_HIST_W-1:0] exec_saved_history;
  logic [SNAP_IDX_W-1:0]  exec_saved_index;

  logic                 hist_we;
  logic [HIST_AW-1:0]   hist_waddr;
  logic [HIST_BITS-1:0] hist_wdata;
  logic                 ctr_we;
  logic [CTR_AW-1:0]    ctr_waddr;
  logic [CTR_BITS-1:0]  ctr_wdata;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign req_in = '{
    cmd:              cmd,
    thread:           thread,
    branch_address:   branch_address,
    outcome_taken:    outcome_taken,
    was_squashed:     was_squashed,
    snapshot_history: snapshot_history,
    snapshot_index:   snapshot_index
  };

  // History address from the incoming request: thread selects the table,
  // low address bits select the entry
  assign tid_in_x   = TID_X_W'(thread);
  assign idx_in_x   = IDX_X_W'(branch_address);
  assign hist_raddr = {tid_in_x[TIDX_W-1:0], idx_in_x[HIST_INDEX_BITS-1:0]};

  // Same addressing for the held request at write-back
  assign tid_q_x      = TID_X_W'(req.thread);
  assign idx_q_x      = IDX_X_W'(req.branch_address);
  assign sidx_q_x     = SIDX_X_W'(req.snapshot_index);
  assign idx_q        = idx_q_x[HIST_INDEX_BITS-1:0];
  assign sidx_q       = sidx_q_x[HIST_INDEX_BITS-1:0];
  assign commit_haddr = {tid_q_x[TIDX_W-1:0], ctrl.use_snap_index ? sidx_q : idx_q};
  assign thread_ok    = (32'(req.thread) < 32'(THREADS));

  // Counter address: history picks the row, branch address picks the column
  assign row_w      = 32'(hist_rdata) & ROW_MASK;
  assign ctr_addr_w = (row_w << COL_BITS) | (32'(req.branch_address) & COL_MASK);

  // Sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr == '1) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_HIST;
      end
      ST_HIST: begin
        state_next = ST_CTR;
      end
      ST_CTR: begin
        // hold until the output register can take the result
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_stall = 1'b1;
    clearing = 1'b0;
    ctr_rd   = 1'b0;
    commit   = 1'b0;
    case (state)
      ST_CLEAR: clearing = 1'b1;
      ST_IDLE:  in_stall = 1'b0;
      ST_HIST:  ctr_rd   = 1'b1;
      ST_CTR:   commit   = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr   <= '0;
    end else begin
      state <= state_next;
      if (clearing) clr <= clr + CLR_W'(1);
    end
  end

  // Capture the request on acceptance
  always_ff @(posedge clk) begin
    if (accept) req <= req_in;
  end

  pabp_exec #(
    .HIST_BITS       (HIST_BITS),
    .CTR_BITS        (CTR_BITS),
    .HIST_INDEX_BITS (HIST_INDEX_BITS)
  ) u_exec (
    .req           (req),
    .thread_ok     (thread_ok),
    .hist          (hist_rdata),
    .ctr           (ctr_rdata),
    .idx           (idx_q),
    .ctrl          (ctrl),
    .hist_wdata    (exec_hist),
    .ctr_wdata     (exec_ctr),
    .predict_taken (exec_predict),
    .saved_history (exec_saved_history),
    .saved_index   (exec_saved_index)
  );

  // Write ports: zero sweep after reset, otherwise write-back of one request
  assign hist_we    = clearing || (commit && ctrl.hist_we);
  assign hist_waddr = clearing ? clr[HIST_AW-1:0] : commit_haddr;
  assign hist_wdata = clearing ? '0 : exec_hist;
  assign ctr_we     = clearing || (commit && ctrl.ctr_we);
  assign ctr_waddr  = clearing ? clr[CTR_AW-1:0] : ctr_addr_q;
  assign ctr_wdata  = clearing ? '0 : exec_ctr;

  // History memory: read on acceptance, written at write-back
  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    if (accept)  hist_rdata <= hist_mem[hist_raddr];
  end

  // Counter memory: read once history is known; keep the address for write-back
  always_ff @(posedge clk) begin
    if (ctr_we) ctr_mem[ctr_waddr] <= ctr_wdata;
    if (ctr_rd) begin
      ctr_rdata  <= ctr_mem[ctr_addr_w[CTR_AW-1:0]];
      ctr_addr_q <= ctr_addr_w[CTR_AW-1:0];
    end
  end

  // Output register: load at write-back, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      predict_taken <= exec_predict;
      saved_history <= exec_saved_history;
      saved_index   <= exec_saved_index;
    end
  end

  // A request accepted now passes through ST_HIST and then reaches write-back (ST_CTR)
  a_accept_to_ctr: assert property (@(posedge clk) disable iff (rst)
    accept |=> ##1 state == ST_CTR)
    else $error("accepted request did not reach write-back");

  // Memories are written only during the sweep or at write-back
  a_write_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_HIST) |-> !(hist_we || ctr_we))
    else $error("memory write outside sweep or write-back");

  // A new result only appears right after write-back
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_CTR)
    else $error("result appeared without write-back");

  // Non-lookup requests return an all-zero result
  a_nonlookup_zero: assert property (@(posedge clk) disable iff (rst)
    (commit && req.cmd != CMD_LOOKUP) |=>
      (!predict_taken && saved_history == '0 && saved_index == '0))
    else $error("non-lookup result not zero");

endmodule

>>> hw/rtl/pabp_exec.sv
module pabp_exec #(
  parameter int HIST_BITS       = 8,
  parameter int CTR_BITS        = 2,
  parameter int HIST_INDEX_BITS = 10
) (
  input  pabp_pkg::req_t                      req,
  input  logic                                thread_ok,
  input  logic [HIST_BITS-1:0]                hist,
  input  logic [CTR_BITS-1:0]                 ctr,
  input  logic [HIST_INDEX_BITS-1:0]          idx,
  output pabp_pkg::exec_ctrl_t                ctrl,
  output logic [HIST_BITS-1:0]                hist_wdata,
  output logic [CTR_BITS-1:0]                 ctr_wdata,
  output logic                                predict_taken,
  output logic [pabp_pkg::SNAP_HIST_W-1:0]    saved_history,
  output logic [pabp_pkg::SNAP_IDX_W-1:0]     saved_index
);
  import pabp_pkg::*;

  localparam int SNAP_X_W = HIST_BITS + SNAP_HIST_W;
  localparam int IDX_X_W  = HIST_INDEX_BITS + SNAP_IDX_W;

  cmd_t                  cmd;
  logic [HIST_BITS:0]    hist_sh;
  logic [HIST_BITS:0]    hist_one;
  logic [SNAP_X_W-1:0]   snap_x;
  logic [SNAP_X_W:0]     snap_sh;
  logic [SNAP_X_W-1:0]   hist_x;
  logic [IDX_X_W-1:0]    idx_x;
  logic [CTR_BITS-1:0]   ctr_up;
  logic [CTR_BITS-1:0]   ctr_dn;

  assign cmd      = cmd_t'(req.cmd);
  assign hist_sh  = {hist, req.outcome_taken};
  assign hist_one = {hist, 1'b1};
  assign snap_x   = SNAP_X_W'(req.snapshot_history);
  assign snap_sh  = {snap_x, req.outcome_taken};
  assign hist_x   = SNAP_X_W'(hist);
  assign idx_x    = IDX_X_W'(idx);

  // Saturating counter steps
  assign ctr_up = (ctr == '1) ? ctr : ctr + CTR_BITS'(1);
  assign ctr_dn = (ctr == '0) ? ctr : ctr - CTR_BITS'(1);

  always_comb begin
    ctrl          = '0;
    hist_wdata    = hist;
    ctr_wdata     = ctr;
    predict_taken = 1'b0;
    saved_history = '0;
    saved_index   = '0;
    if (thread_ok) begin
      case (cmd)
        CMD_LOOKUP: begin
          predict_taken = (ctr > CTR_BITS'(1));
          saved_history = hist_x[SNAP_HIST_W-1:0];
          saved_index   = idx_x[SNAP_IDX_W-1:0];
        end
        CMD_UPDATE: begin
          ctrl.hist_we = 1'b1;
          if (req.was_squashed) begin
            // rebuild from the snapshot, leave the counter alone
            hist_wdata = snap_sh[HIST_BITS-1:0];
          end else begin
            hist_wdata   = hist_sh[HIST_BITS-1:0];
            ctrl.ctr_we  = 1'b1;
            ctr_wdata    = req.outcome_taken ? ctr_up : ctr_dn;
          end
        end
        CMD_SQUASH: begin
          ctrl.hist_we        = 1'b1;
          ctrl.use_snap_index = 1'b1;
          hist_wdata          = snap_x[HIST_BITS-1:0];
        end
        CMD_BTB_UPDATE: begin
          ctrl.hist_we = 1'b1;
          hist_wdata   = hist & ~HIST_BITS'(1);
        end
        CMD_UNCOND: begin
          ctrl.hist_we = 1'b1;
          ctrl.ctr_we  = 1'b1;
          hist_wdata   = hist_one[HIST_BITS-1:0];
          ctr_wdata    = ctr_up;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import pabp_pkg::*;

  // Geometry of the unit under test (its default parameters)
  localparam int THREADS         = 4;
  localparam int HIST_INDEX_BITS = 10;
  localparam int ROW_BITS        = 8;
  localparam int COL_BITS        = 4;
  localparam int HIST_BITS       = 8;
  localparam int CTR_BITS        = 2;
  localparam int CTR_MAX         = (1 << CTR_BITS) - 1;

  // Command codes the unit does not implement; they must come back all zero
  localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

  // Run control
  localparam int STALL_LIMIT   = 20000;  // covers the clearing sweep
  localparam int LONG_HOLD     = 300;
  localparam int DRAIN_CYCLES  = 8;
  localparam int MAX_REPORTS   = 10;
  localparam int RANDOM_ITEMS  = 520;
  localparam int PRESSURE_REQS = 40;

  typedef struct packed {
    logic                   predict_taken;
    logic [SNAP_HIST_W-1:0] saved_history;
    logic [SNAP_IDX_W-1:0]  saved_index;
  } branch_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   in_valid         = 1'b0;
  logic                   in_stall;
  logic [CMD_W-1:0]       cmd              = '0;
  logic [THREAD_W-1:0]    thread           = '0;
  logic [ADDR_W-1:0]      branch_address   = '0;
  logic                   outcome_taken    = 1'b0;
  logic                   was_squashed     = 1'b0;
  logic [SNAP_HIST_W-1:0] snapshot_history = '0;
  logic [SNAP_IDX_W-1:0]  snapshot_index   = '0;

  logic                   out_valid;
  logic                   out_stall        = 1'b0;
  logic                   predict_taken;
  logic [SNAP_HIST_W-1:0] saved_history;
  logic [SNAP_IDX_W-1:0]  saved_index;

  // Shadow copy of the unit's two tables
  logic [HIST_BITS-1:0] hist_table [THREADS][1 << HIST_INDEX_BITS];
  logic [CTR_BITS-1:0]  ctr_table  [1 << ROW_BITS][1 << COL_BITS];

  // Results predicted for accepted requests, oldest first
  branch_result_t pending_predictions [$];

  int unsigned mismatches     = 0;
  int unsigned idle_cycles    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Long receiver hold: the test flips hold_toggle, the stall process counts
  logic        hold_toggle = 1'b0;
  logic        hold_seen   = 1'b0;
  int unsigned hold_left   = 0;

  // Working set for the random traffic: a few hot branches, each column
  // with its own taken bias so that counters drift both ways
  logic [ADDR_W-1:0] hot_addr    [16];
  int unsigned       taken_bias  [1 << COL_BITS];

  per_address_two_level_branch_predictor_unit uut (.*);

  always #6 clk = ~clk;

  // Train one saturating counter up or down
  function automatic void train_counter(input logic [ROW_BITS-1:0] row,
                                        input logic [COL_BITS-1:0] col,
                                        input logic up);
    if (up) begin
      if (ctr_table[row][col] != CTR_MAX)
        ctr_table[row][col] = ctr_table[row][col] + CTR_BITS'(1);
    end else begin
      if (ctr_table[row][col] != 0)
        ctr_table[row][col] = ctr_table[row][col] - CTR_BITS'(1);
    end
  endfunction

  // Apply one request to the shadow tables and return the result it yields
  function automatic branch_result_t apply_branch_request(input req_t req);
    branch_result_t             res;
    logic [HIST_INDEX_BITS-1:0] idx;
    logic [HIST_BITS-1:0]       hist;
    logic [ROW_BITS-1:0]        row;
    logic [COL_BITS-1:0]        col;
    res = '0;
    // Reserved commands and absent threads leave everything alone
    if (req.thread >= THREADS || req.cmd > CMD_UNCOND) return res;
    idx  = req.branch_address[HIST_INDEX_BITS-1:0];
    hist = hist_table[req.thread][idx];
    row  = hist[ROW_BITS-1:0];
    col  = req.branch_address[COL_BITS-1:0];
    case (req.cmd)
      CMD_LOOKUP: begin
        res.predict_taken = (ctr_table[row][col] > 1);
        res.saved_history = hist;
        res.saved_index   = idx;
      end
      CMD_UPDATE: begin
        if (req.was_squashed) begin
          // Rebuild from the snapshot, counters untouched
          hist_table[req.thread][idx] = {req.snapshot_history[HIST_BITS-2:0], req.outcome_taken};
        end else begin
          hist_table[req.thread][idx] = {hist[HIST_BITS-2:0], req.outcome_taken};
          train_counter(row, col, req.outcome_taken);
        end
      end
      CMD_SQUASH: begin
        hist_table[req.thread][req.snapshot_index[HIST_INDEX_BITS-1:0]] =
          req.snapshot_history[HIST_BITS-1:0];
      end
      CMD_BTB_UPDATE: begin
        hist_table[req.thread][idx] = {hist[HIST_BITS-1:1], 1'b0};
      end
      CMD_UNCOND: begin
        hist_table[req.thread][idx] = {hist[HIST_BITS-2:0], 1'b1};
        train_counter(row, col, 1'b1);
      end
      default: ;
    endcase
    return res;
  endfunction

  // Offer one request, hold it until accepted, then log its expected result
  task automatic send_request(input logic [CMD_W-1:0]       op,
                              input logic [THREAD_W-1:0]    th,
                              input logic [ADDR_W-1:0]      addr,
                              input logic                   taken,
                              input logic                   squashed,
                              input logic [SNAP_HIST_W-1:0] snap_hist,
                              input logic [SNAP_IDX_W-1:0]  snap_idx);
    req_t req;
    req = '{op, th, addr, taken, squashed, snap_hist, snap_idx};
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    cmd              <= op;
    thread           <= th;
    branch_address   <= addr;
    outcome_taken    <= taken;
    was_squashed     <= squashed;
    snapshot_history <= snap_hist;
    snapshot_index   <= snap_idx;
    in_valid         <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_predictions.push_back(apply_branch_request(req));
  endtask

  // Fully random request: any command code, any field value
  task automatic send_noise();
    send_request(CMD_W'($urandom_range(7)), THREAD_W'($urandom_range(THREADS - 1)),
                 ADDR_W'($urandom_range(1023)), 1'($urandom_range(1)),
                 1'($urandom_range(1)), SNAP_HIST_W'($urandom_range(255)),
                 SNAP_IDX_W'($urandom_range(1023)));
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch on %s at %0t: expected %0h, got %0h", what, $time, want, got);
  endtask

  // Directed corner cases, each request chosen by hand
  task automatic test_directed();
    // Untouched tables: lookup at the lowest corner predicts not taken
    send_request(CMD_LOOKUP, 2'd0, 10'd0, 1'b0, 1'b0, 8'h00, 10'd0);
    // Saturate one counter: unconditional branches from the same history,
    // restoring that history with a squash between them
    repeat (4) begin
      send_request(CMD_UNCOND, 2'd3, 10'd1023, 1'b1, 1'b1, 8'hFF, 10'd1023);
      send_request(CMD_SQUASH, 2'd3, 10'd1023, 1'b1, 1'b1, 8'h00, 10'd1023);
    end
    send_request(CMD_LOOKUP, 2'd3, 10'd1023, 1'b1, 1'b1, 8'hFF, 10'd1023);
    // Decrement at zero stays at zero
    send_request(CMD_UPDATE, 2'd1, 10'h155, 1'b0, 1'b0, 8'hFF, 10'd1023);
    send_request(CMD_LOOKUP, 2'd1, 10'h155, 1'b0, 1'b0, 8'h00, 10'd0);
    // Squashed update rebuilds from the snapshot; top bit shifts out
    send_request(CMD_UPDATE, 2'd2, 10'h2AA, 1'b1, 1'b1, 8'hFF, 10'd0);
    send_request(CMD_LOOKUP, 2'd2, 10'h2AA, 1'b0, 1'b0, 8'h00, 10'd0);
    // BTB update clears only the newest history bit
    send_request(CMD_BTB_UPDATE, 2'd2, 10'h2AA, 1'b1, 1'b1, 8'hFF, 10'd1023);
    send_request(CMD_LOOKUP, 2'd2, 10'h2AA, 1'b0, 1'b0, 8'h00, 10'd0);
    // Squash writes the entry named by the snapshot index, not the address
    send_request(CMD_SQUASH, 2'd0, 10'd0, 1'b0, 1'b0, 8'hA5, 10'd1023);
    send_request(CMD_LOOKUP, 2'd0, 10'd1023, 1'b0, 1'b0, 8'h00, 10'd0);
    // Reserved command codes with every other field high
    send_request(CMD_RSVD5, 2'd3, 10'd1023, 1'b1, 1'b1, 8'hFF, 10'd1023);
    send_request(CMD_RSVD6, 2'd3, 10'd1023, 1'b1, 1'b1, 8'hFF, 10'd1023);
    send_request(CMD_RSVD7, 2'd3, 10'd1023, 1'b1, 1'b1, 8'hFF, 10'd1023);
  endtask

  // Mostly well-formed lookup / resolve sequences over a hot working set,
  // with some noise and broken snapshots mixed in
  task automatic test_random_traffic(input int unsigned count);
    int unsigned          sent;
    int unsigned          pick;
    logic [THREAD_W-1:0]  th;
    logic [ADDR_W-1:0]    addr;
    logic [HIST_BITS-1:0] snap;
    logic                 taken;
    sent = 0;
    while (sent < count) begin
      th   = THREAD_W'($urandom_range(THREADS - 1));
      addr = ($urandom_range(3) == 0) ? ADDR_W'($urandom_range(1023))
                                      : hot_addr[$urandom_range(15)];
      pick = $urandom_range(99);
      if (pick < 10) begin
        send_noise();
        sent++;
      end else begin
        // The lookup will report exactly what the shadow table holds now
        snap = hist_table[th][addr[HIST_INDEX_BITS-1:0]];
        send_request(CMD_LOOKUP, th, addr, 1'($urandom_range(1)), 1'($urandom_range(1)),
                     SNAP_HIST_W'($urandom_range(255)), SNAP_IDX_W'($urandom_range(1023)));
        sent++;
        taken = ($urandom_range(99) < taken_bias[addr[COL_BITS-1:0]]);
        pick  = $urandom_range(99);
        if (pick < 55) begin
          send_request(CMD_UPDATE, th, addr, taken, 1'b0, SNAP_HIST_W'($urandom_range(255)),
                       SNAP_IDX_W'($urandom_range(1023)));
          sent++;
        end else if (pick < 70) begin
          // Wrong path: restore, then resolve against the snapshot;
          // now and then the snapshot is stale
          if ($urandom_range(9) == 0) snap = HIST_BITS'($urandom_range(255));
          send_request(CMD_SQUASH, th, ADDR_W'($urandom_range(1023)), 1'($urandom_range(1)),
                       1'($urandom_range(1)), snap, addr);
          send_request(CMD_UPDATE, th, addr, taken, 1'b1, snap,
                       SNAP_IDX_W'($urandom_range(1023)));
          sent += 2;
        end else if (pick < 80) begin
          send_request(CMD_BTB_UPDATE, th, addr, 1'($urandom_range(1)),
                       1'($urandom_range(1)), SNAP_HIST_W'($urandom_range(255)),
                       SNAP_IDX_W'($urandom_range(1023)));
          sent++;
        end else if (pick < 90) begin
          send_request(CMD_UNCOND, th, addr, 1'($urandom_range(1)),
                       1'($urandom_range(1)), SNAP_HIST_W'($urandom_range(255)),
                       SNAP_IDX_W'($urandom_range(1023)));
          sent++;
        end
      end
    end
  endtask

  // Hold the output for a long stretch while requests keep coming,
  // so the unit fills up and stalls its input
  task automatic test_output_backpressure();
    hold_toggle <= ~hold_toggle;
    test_random_traffic(PRESSURE_REQS);
  endtask

  // Receiver: random stalls, or a long hold when the test asks for one
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_seen <= hold_toggle;
    end else if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_results
    branch_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_predictions.size() == 0) begin
        flag_mismatch("unexpected result (out_valid)", 0, 1);
      end else begin
        want = pending_predictions.pop_front();
        if (predict_taken !== want.predict_taken)
          flag_mismatch("predict_taken", 32'(want.predict_taken), 32'(predict_taken));
        if (saved_history !== want.saved_history)
          flag_mismatch("saved_history", 32'(want.saved_history), 32'(saved_history));
        if (saved_index !== want.saved_index)
          flag_mismatch("saved_index", 32'(want.saved_index), 32'(saved_index));
      end
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int t = 0; t < THREADS; t++)
      for (int i = 0; i < (1 << HIST_INDEX_BITS); i++) hist_table[t][i] = '0;
    for (int r = 0; r < (1 << ROW_BITS); r++)
      for (int c = 0; c < (1 << COL_BITS); c++) ctr_table[r][c] = '0;
    for (int i = 0; i < 16; i++) hot_addr[i] = ADDR_W'($urandom_range(1023));
    for (int c = 0; c < (1 << COL_BITS); c++) begin
      case ($urandom_range(4))
        0: taken_bias[c] = 0;
        1: taken_bias[c] = 10;
        2: taken_bias[c] = 50;
        3: taken_bias[c] = 90;
        default: taken_bias[c] = 100;
      endcase
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Phase one: sender idles often, receiver stalls more
    send_idle_pct  = 33;
    recv_stall_pct = 57;
    test_directed();
    test_random_traffic(RANDOM_ITEMS);

    // Phase two: roles swapped
    send_idle_pct  = 57;
    recv_stall_pct = 33;
    test_random_traffic(RANDOM_ITEMS);

    // Phase three: full rate on both sides, one long output hold first
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_output_backpressure();
    test_random_traffic(RANDOM_ITEMS);
    in_valid <= 1'b0;

    // Drain, then give the pipeline time to show any extra result
    while (pending_predictions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
